[rtl/dfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and constants for the EEG sample word deframer.
// ----------------------------------------------------------------------------
package dfr_pkg;

    localparam int CHANNELS = 8;
    localparam int WORDS    = CHANNELS + 1;
    localparam int BYTES    = 4 * WORDS;
    localparam int POS_W    = $clog2(BYTES);
    localparam int WIDX_W   = $clog2(WORDS);
    localparam int WORD_W   = 24;
    localparam int SEQ_W    = 32;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BYTES - 1);

    // operation codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_DROP  = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;

    // byte lane of a 24-bit word; LANE_NONE marks the discarded byte
    localparam logic [1:0] LANE_LO   = 2'd0;
    localparam logic [1:0] LANE_MID  = 2'd1;
    localparam logic [1:0] LANE_HI   = 2'd2;
    localparam logic [1:0] LANE_NONE = 2'd3;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word t_word_arr [WORDS];

    typedef struct packed {
        logic              en;
        logic [WIDX_W-1:0] word;
        logic [1:0]        lane;
        logic [7:0]        data;
    } t_store_wr;

    typedef struct packed {
        logic [SEQ_W-1:0]          frame_seq;
        logic [7:0]                lead_off_pos;
        logic [7:0]                lead_off_neg;
        logic [3:0]                gpio_bits;
        logic signed [WORD_W-1:0]  chan0;
        logic signed [WORD_W-1:0]  chan1;
        logic signed [WORD_W-1:0]  chan2;
        logic signed [WORD_W-1:0]  chan3;
        logic signed [WORD_W-1:0]  chan4;
        logic signed [WORD_W-1:0]  chan5;
        logic signed [WORD_W-1:0]  chan6;
        logic signed [WORD_W-1:0]  chan7;
    } t_frame;

endpackage

[rtl/dfr_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_in_if / dfr_out_if
// Valid/ready stream channels for the byte input and the frame output.
// ----------------------------------------------------------------------------
interface dfr_in_if
    import dfr_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface dfr_out_if
    import dfr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [SEQ_W-1:0]         frame_seq;
    logic [7:0]               lead_off_pos;
    logic [7:0]               lead_off_neg;
    logic [3:0]               gpio_bits;
    logic signed [WORD_W-1:0] chan0;
    logic signed [WORD_W-1:0] chan1;
    logic signed [WORD_W-1:0] chan2;
    logic signed [WORD_W-1:0] chan3;
    logic signed [WORD_W-1:0] chan4;
    logic signed [WORD_W-1:0] chan5;
    logic signed [WORD_W-1:0] chan6;
    logic signed [WORD_W-1:0] chan7;

    modport source (
        output valid, output frame_seq, output lead_off_pos, output lead_off_neg,
        output gpio_bits, output chan0, output chan1, output chan2, output chan3,
        output chan4, output chan5, output chan6, output chan7, input ready
    );
    modport sink (
        input valid, input frame_seq, input lead_off_pos, input lead_off_neg,
        input gpio_bits, input chan0, input chan1, input chan2, input chan3,
        input chan4, input chan5, input chan6, input chan7, output ready
    );
endinterface

[rtl/dfr_word_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_word_store
// Nine 24-bit word registers, written one byte lane at a time. Also gives
// the contents as they stand after this cycle's write.
// ----------------------------------------------------------------------------
module dfr_word_store
    import dfr_pkg::*;
(
    input  logic      i_clk,
    input  t_store_wr i_wr,
    output t_word_arr o_words_next
);

    t_word_arr r_words;
    t_word_arr n_words;

    always_comb begin
        n_words = r_words;
        if (i_wr.en) begin
            case (i_wr.lane)
                LANE_LO:  n_words[i_wr.word][7:0]   = i_wr.data;
                LANE_MID: n_words[i_wr.word][15:8]  = i_wr.data;
                LANE_HI:  n_words[i_wr.word][23:16] = i_wr.data;
                default:  n_words = r_words;
            endcase
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_words <= n_words;
    end

    assign o_words_next = n_words;

endmodule

[rtl/eeg_sample_word_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeg_sample_word_deframer
// Groups stream bytes into 36-byte samples and emits one decoded frame each.
// ----------------------------------------------------------------------------
// Throughput: one input transfer per cycle, except while the last byte of a sample stalls.
// Output: the frame is valid in the cycle after the transfer of a sample's last byte.
// The last byte of a sample stalls only while the previous frame is still held.
// Reset (synchronous, active low): byte position, sequence number, output valid
// and word order clear; the word registers are not reset.
module eeg_sample_word_deframer
    import dfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    dfr_in_if.sink           i_in,
    dfr_out_if.source        o_out
);

    logic             r_word_order;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [SEQ_W-1:0] r_seq;
    logic [SEQ_W-1:0] n_seq;
    logic             r_out_valid;
    logic             n_out_valid;
    t_frame           r_frame;
    t_frame           n_frame;

    logic             in_xfer;
    logic             at_last;
    logic             frame_load;
    logic [1:0]       lane;
    t_store_wr        store_wr;
    t_word_arr        words_next;

    assign at_last    = (r_pos >= POS_LAST);
    assign i_in.ready = !(r_out_valid && !o_out.ready && at_last);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign frame_load = in_xfer && (i_in.operation == OP_PUSH) && at_last;

    // big-endian: byte 0 dropped, 1..3 go high to low; little-endian: byte 3 dropped
    always_comb begin
        if (r_word_order) begin
            lane = r_pos[1:0];
        end else begin
            lane = 2'(LANE_NONE - r_pos[1:0]);
        end
    end

    assign store_wr.en   = in_xfer && (i_in.operation == OP_PUSH) && (lane != LANE_NONE);
    assign store_wr.word = at_last ? WIDX_W'(WORDS - 1) : r_pos[POS_W-1:2];
    assign store_wr.lane = at_last ? (r_word_order ? LANE_NONE : LANE_LO) : lane;
    assign store_wr.data = i_in.data_byte;

    dfr_word_store u_store (
        .i_clk        (i_clk),
        .i_wr         (store_wr),
        .o_words_next (words_next)
    );

    always_comb begin
        n_pos = r_pos;
        n_seq = r_seq;
        if (in_xfer) begin
            case (i_in.operation)
                OP_PUSH: begin
                    if (at_last) begin
                        n_pos = '0;
                        n_seq = r_seq + 1'b1;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                OP_DROP: begin
                    n_pos = '0;
                end
                OP_RESET: begin
                    n_pos = '0;
                    n_seq = '0;
                end
                default: begin
                    n_pos = r_pos;
                end
            endcase
        end
    end

    always_comb begin
        n_frame              = r_frame;
        n_out_valid          = r_out_valid && !o_out.ready;
        if (frame_load) begin
            n_out_valid          = 1'b1;
            n_frame.frame_seq    = r_seq;
            n_frame.lead_off_pos = words_next[0][19:12];
            n_frame.lead_off_neg = words_next[0][11:4];
            n_frame.gpio_bits    = words_next[0][3:0];
            n_frame.chan0        = words_next[1];
            n_frame.chan1        = words_next[2];
            n_frame.chan2        = words_next[3];
            n_frame.chan3        = words_next[4];
            n_frame.chan4        = words_next[5];
            n_frame.chan5        = words_next[6];
            n_frame.chan6        = words_next[7];
            n_frame.chan7        = words_next[8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_order <= 1'b0;
            r_pos        <= '0;
            r_seq        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_word_order <= i_cfg_wdata;
            end
            r_pos       <= n_pos;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.frame_seq    = r_frame.frame_seq;
    assign o_out.lead_off_pos = r_frame.lead_off_pos;
    assign o_out.lead_off_neg = r_frame.lead_off_neg;
    assign o_out.gpio_bits    = r_frame.gpio_bits;
    assign o_out.chan0        = r_frame.chan0;
    assign o_out.chan1        = r_frame.chan1;
    assign o_out.chan2        = r_frame.chan2;
    assign o_out.chan3        = r_frame.chan3;
    assign o_out.chan4        = r_frame.chan4;
    assign o_out.chan5        = r_frame.chan5;
    assign o_out.chan6        = r_frame.chan6;
    assign o_out.chan7        = r_frame.chan7;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("byte position beyond sample length");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !frame_load)
        else $error("held frame overwritten");

    a_frame_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_load |=> (r_out_valid && r_frame.frame_seq == $past(r_seq)))
        else $error("frame not loaded with its sequence number");

    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_load |=> (r_seq == $past(r_seq) + 1'b1) && (r_pos == '0))
        else $error("sequence or position not advanced after frame");
`endif

endmodule
